/* rtl/core/hkrd_pkg.sv */
package hkrd_pkg;

  localparam int unsigned KEY_W = 8;
  localparam int unsigned LED_W = 3;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam logic [KEY_W-1:0] KEY_NONE   = 8'h00;
  localparam logic [KEY_W-1:0] KEY_CAPS   = 8'h39;
  localparam logic [KEY_W-1:0] KEY_SCROLL = 8'h47;
  localparam logic [KEY_W-1:0] KEY_NUM    = 8'h53;

  localparam int unsigned LED_NUM_BIT    = 0;
  localparam int unsigned LED_CAPS_BIT   = 1;
  localparam int unsigned LED_SCROLL_BIT = 2;

  typedef enum logic [1:0] {
    KIND_MAKE  = 2'd0,
    KIND_BREAK = 2'd1,
    KIND_LED   = 2'd2
  } kind_e;

  typedef struct packed {
    logic make;
    logic brk;
    logic caps;
    logic scroll;
    logic num;
  } lane_t;

endpackage

/* rtl/core/hid_keyboard_report_diff.sv */
// a report's events load into the pending register when its beat is accepted,
//   then each event passes into the output register
// throughput: one event per cycle unless the output stalls; the next report
//   is accepted as the last event of the previous one enters the output register
// reset: clears key history, lock toggles, led mask, pending events and output valid
module hid_keyboard_report_diff #(
  parameter int unsigned KeySlots = 6
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // modifier_bits, key_slot_0 .. key_slot_n
  input  logic [hkrd_pkg::KEY_W*(KeySlots+1)-1:0] s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // event_key, event_modifier, led_mask, zero fill
  output logic [hkrd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // event_kind
  output logic [1:0]                         m_axis_tuser,
  // last_of_run
  output logic                               m_axis_tlast
);
  import hkrd_pkg::*;

  logic [KeySlots-1:0][KEY_W-1:0] cur_keys;
  logic [KeySlots-1:0][KEY_W-1:0] prev_q;
  logic [KEY_W-1:0]               mod;
  lane_t [KeySlots-1:0]           lanes;

  logic                           caps_q, scroll_q, num_q;
  logic [LED_W-1:0]               led_q;
  logic                           caps_d, scroll_d, num_d;
  logic [LED_W-1:0]               led_d;
  logic [KeySlots-1:0][LED_W-1:0] make_led;

  logic [KeySlots-1:0]            make_vec;
  logic [KeySlots-1:0]            brk_vec;
  logic [2*KeySlots:0]            pend;
  logic                           take;
  logic                           accept;

  assign mod = s_axis_tdata[KEY_W-1:0];

  for (genvar i = 0; i < KeySlots; i++) begin : g_lane
    assign cur_keys[i] = s_axis_tdata[KEY_W*(i+1) +: KEY_W];
    assign make_vec[i] = lanes[i].make;
    assign brk_vec[i]  = lanes[i].brk;

    hkrd_lane #(
      .KeySlots(KeySlots)
    ) u_lane (
      .cur_key_i  (cur_keys[i]),
      .prev_key_i (prev_q[i]),
      .cur_keys_i (cur_keys),
      .prev_keys_i(prev_q),
      .lane_o     (lanes[i])
    );
  end

  // lock toggles walk the slots in order so each make sees the led state before it
  always_comb begin
    caps_d   = caps_q;
    scroll_d = scroll_q;
    num_d    = num_q;
    led_d    = led_q;
    for (int i = 0; i < KeySlots; i++) begin
      make_led[i] = led_d;
      if (lanes[i].caps) begin
        caps_d              = ~caps_d;
        led_d[LED_CAPS_BIT] = caps_d;
      end
      if (lanes[i].scroll) begin
        scroll_d              = ~scroll_d;
        led_d[LED_SCROLL_BIT] = scroll_d;
      end
      if (lanes[i].num) begin
        num_d              = ~num_d;
        led_d[LED_NUM_BIT] = ~num_d;
      end
    end
  end

  assign pend          = {(led_d != led_q), brk_vec, make_vec};
  assign s_axis_tready = take;
  assign accept        = s_axis_tvalid && take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      caps_q   <= 1'b0;
      scroll_q <= 1'b0;
      num_q    <= 1'b0;
      led_q    <= '0;
    end else if (accept) begin
      prev_q   <= cur_keys;
      caps_q   <= caps_d;
      scroll_q <= scroll_d;
      num_q    <= num_d;
      led_q    <= led_d;
    end
  end

  hkrd_emit #(
    .KeySlots(KeySlots)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .pend_i       (pend),
    .cur_keys_i   (cur_keys),
    .prev_keys_i  (prev_q),
    .make_led_i   (make_led),
    .led_i        (led_d),
    .mod_i        (mod),
    .take_o       (take),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

/* rtl/core/hkrd_lane.sv */
module hkrd_lane #(
  parameter int unsigned KeySlots = 6
) (
  input  logic [hkrd_pkg::KEY_W-1:0]               cur_key_i,
  input  logic [hkrd_pkg::KEY_W-1:0]               prev_key_i,
  input  logic [KeySlots-1:0][hkrd_pkg::KEY_W-1:0] cur_keys_i,
  input  logic [KeySlots-1:0][hkrd_pkg::KEY_W-1:0] prev_keys_i,
  output hkrd_pkg::lane_t                          lane_o
);
  import hkrd_pkg::*;

  logic in_prev;
  logic in_cur;
  logic is_new;
  logic prev_lock;

  always_comb begin
    in_prev = 1'b0;
    in_cur  = 1'b0;
    for (int j = 0; j < KeySlots; j++) begin
      in_prev = in_prev | (prev_keys_i[j] == cur_key_i);
      in_cur  = in_cur  | (cur_keys_i[j] == prev_key_i);
    end
  end

  assign is_new    = (cur_key_i != KEY_NONE) && !in_prev;
  assign prev_lock = (prev_key_i == KEY_CAPS) || (prev_key_i == KEY_SCROLL) ||
                     (prev_key_i == KEY_NUM);

  assign lane_o.caps   = is_new && (cur_key_i == KEY_CAPS);
  assign lane_o.scroll = is_new && (cur_key_i == KEY_SCROLL);
  assign lane_o.num    = is_new && (cur_key_i == KEY_NUM);
  assign lane_o.make   = is_new && !lane_o.caps && !lane_o.scroll && !lane_o.num;
  assign lane_o.brk    = (prev_key_i != KEY_NONE) && !in_cur && !prev_lock;

endmodule

/* rtl/core/hkrd_emit.sv */
module hkrd_emit #(
  parameter int unsigned KeySlots = 6
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     load_i,
  input  logic [2*KeySlots:0]                      pend_i,
  input  logic [KeySlots-1:0][hkrd_pkg::KEY_W-1:0] cur_keys_i,
  input  logic [KeySlots-1:0][hkrd_pkg::KEY_W-1:0] prev_keys_i,
  input  logic [KeySlots-1:0][hkrd_pkg::LED_W-1:0] make_led_i,
  input  logic [hkrd_pkg::LED_W-1:0]               led_i,
  input  logic [hkrd_pkg::KEY_W-1:0]               mod_i,
  output logic                                     take_o,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // event_key, event_modifier, led_mask, zero fill
  output logic [hkrd_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  // event_kind
  output logic [1:0]                               m_axis_tuser,
  output logic                                     m_axis_tlast
);
  import hkrd_pkg::*;

  localparam int unsigned PendW = 2 * KeySlots + 1;
  localparam int unsigned PadW  = OUT_TDATA_W - 2 * KEY_W - LED_W;

  logic [PendW-1:0]                  pend_q, pend_d;
  logic [KeySlots-1:0][KEY_W-1:0]    cur_q;
  logic [KeySlots-1:0][KEY_W-1:0]    prev_q;
  logic [KeySlots-1:0][LED_W-1:0]    make_led_q;
  logic [LED_W-1:0]                  led_q;
  logic [KEY_W-1:0]                  mod_q;

  logic [PendW-1:0] lowest;
  logic [PendW-1:0] rest;
  logic             job_valid;
  logic             adv;
  logic             last;

  kind_e            ev_kind;
  logic [KEY_W-1:0] ev_key;
  logic [LED_W-1:0] ev_led;

  logic             out_valid_q, out_valid_d;
  kind_e            out_kind_q;
  logic [KEY_W-1:0] out_key_q;
  logic [KEY_W-1:0] out_mod_q;
  logic [LED_W-1:0] out_led_q;
  logic             out_last_q;

  assign job_valid = |pend_q;
  assign lowest    = pend_q & (~pend_q + PendW'(1));
  assign rest      = pend_q & ~lowest;
  assign last      = (rest == '0);
  assign adv       = job_valid && (!out_valid_q || m_axis_tready);
  assign take_o    = !job_valid || (adv && last);

  always_comb begin
    ev_kind = KIND_LED;
    ev_key  = KEY_NONE;
    ev_led  = led_q;
    for (int i = 0; i < KeySlots; i++) begin
      if (lowest[i]) begin
        ev_kind = KIND_MAKE;
        ev_key  = cur_q[i];
        ev_led  = make_led_q[i];
      end
      if (lowest[KeySlots+i]) begin
        ev_kind = KIND_BREAK;
        ev_key  = prev_q[i];
      end
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (load_i) begin
      pend_d = pend_i;
    end else if (adv) begin
      pend_d = rest;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cur_q      <= cur_keys_i;
      prev_q     <= prev_keys_i;
      make_led_q <= make_led_i;
      led_q      <= led_i;
      mod_q      <= mod_i;
    end
    if (adv) begin
      out_kind_q <= ev_kind;
      out_key_q  <= ev_key;
      out_mod_q  <= mod_q;
      out_led_q  <= ev_led;
      out_last_q <= last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {PadW'(0), out_led_q, out_mod_q, out_key_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  a_load_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> take_o)
    else $error("job loaded while previous job still pending");

  a_last_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && last |=> m_axis_tvalid && m_axis_tlast)
    else $error("final event of a report not marked last");

  a_led_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_LED) |-> m_axis_tlast)
    else $error("led update not the final event");

endmodule
